// ===== rtl/bam_pkg.sv =====
// ----------------------------------------------------------------------------
// Brown-out alarm monitor package
// Shared types and constants for the window classifier and alarm tracker.
// ----------------------------------------------------------------------------
package bam_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_LONG_LOW_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_SHORT_LOW_MIN      = 2'd1;
  localparam logic [1:0] REG_SHORT_LOW_MAX      = 2'd2;

  // Configuration reset values, truncated to the count width where used.
  localparam logic [31:0] LONG_LOW_RESET  = 32'd4000000;
  localparam logic [31:0] SHORT_MIN_RESET = 32'd80000;
  localparam logic [31:0] SHORT_MAX_RESET = 32'd400000;

  // Alarm mode codes.
  localparam logic [1:0] MODE_NONE      = 2'd0;
  localparam logic [1:0] MODE_SUSTAINED = 2'd1;
  localparam logic [1:0] MODE_PULSED    = 2'd2;

  // Window run thresholds and limits.
  localparam logic [3:0] RUN_TO_SET          = 4'd3;
  localparam logic [3:0] RUN_MAX             = 4'd15;
  localparam logic [5:0] QUIET_TO_CLEAR_RUNS = 6'd10;
  localparam logic [5:0] QUIET_TO_CLEAR_MODE = 6'd50;

  // Classification of one sampling window; neither bit set means quiet.
  typedef struct packed {
    logic sustained;
    logic pulsed;
  } window_class_t;

endpackage

// ===== rtl/bam_classify.sv =====
// ----------------------------------------------------------------------------
// Brown-out window classifier
// Compares one window's low time and edge count against the thresholds.
// ----------------------------------------------------------------------------
module bam_classify
  import bam_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  logic [COUNT_WIDTH-1:0] low_time,
  input  logic [COUNT_WIDTH-1:0] edges,
  input  logic [COUNT_WIDTH-1:0] long_low_threshold,
  input  logic [COUNT_WIDTH-1:0] short_low_min,
  input  logic [COUNT_WIDTH-1:0] short_low_max,
  output window_class_t          win_class
);

  logic is_long;
  logic in_short_range;
  logic multi_edge;

  // Sustained takes priority over pulsed.
  assign is_long        = low_time > long_low_threshold;
  assign in_short_range = (low_time > short_low_min) && (low_time < short_low_max);
  assign multi_edge     = edges > COUNT_WIDTH'(1);

  assign win_class.sustained = is_long;
  assign win_class.pulsed    = !is_long && in_short_range && multi_edge;

endmodule

// ===== rtl/bam_tracker.sv =====
// ----------------------------------------------------------------------------
// Brown-out alarm tracker
// Holds the window run counters, alarm mode and LED state, and registers the
// result for each classified window.
// ----------------------------------------------------------------------------
module bam_tracker
  import bam_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          update,
  input  window_class_t win_class,
  output logic          led_on,
  output logic [1:0]    alarm_mode
);

  logic [5:0] quiet_windows;
  logic [3:0] sustained_windows;
  logic [3:0] pulsed_windows;
  logic [1:0] mode_reg;
  logic       window_parity;
  logic       led_reg;

  logic [5:0] quiet_windows_next;
  logic [3:0] sustained_windows_next;
  logic [3:0] pulsed_windows_next;
  logic [1:0] mode_reg_next;
  logic       window_parity_next;
  logic       led_reg_next;
  logic [5:0] quiet_inc;

  assign quiet_inc = quiet_windows + 6'd1;

  // Run counters and alarm mode for this window.
  always_comb begin
    quiet_windows_next     = quiet_windows;
    sustained_windows_next = sustained_windows;
    pulsed_windows_next    = pulsed_windows;
    mode_reg_next          = mode_reg;
    window_parity_next     = ~window_parity;
    if (win_class.sustained) begin
      quiet_windows_next = '0;
      if (sustained_windows < RUN_MAX) begin
        sustained_windows_next = sustained_windows + 4'd1;
      end
      if (sustained_windows_next > RUN_TO_SET) begin
        mode_reg_next = MODE_SUSTAINED;
      end
    end else if (win_class.pulsed) begin
      quiet_windows_next = '0;
      if (pulsed_windows < RUN_MAX) begin
        pulsed_windows_next = pulsed_windows + 4'd1;
      end
      if (pulsed_windows_next > RUN_TO_SET) begin
        mode_reg_next = MODE_PULSED;
      end
    end else begin
      quiet_windows_next = quiet_inc;
      if (quiet_inc > QUIET_TO_CLEAR_RUNS) begin
        sustained_windows_next = '0;
        pulsed_windows_next    = '0;
      end
      if (quiet_inc > QUIET_TO_CLEAR_MODE) begin
        quiet_windows_next = '0;
        mode_reg_next      = MODE_NONE;
      end
    end
  end

  // LED blinks every window in sustained mode, every second window in pulsed mode.
  always_comb begin
    case (mode_reg_next)
      MODE_SUSTAINED: led_reg_next = ~led_reg;
      MODE_PULSED:    led_reg_next = window_parity_next ? led_reg : ~led_reg;
      default:        led_reg_next = 1'b0;
    endcase
  end

  // State registers advance once per window.
  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_windows     <= '0;
      sustained_windows <= '0;
      pulsed_windows    <= '0;
      mode_reg          <= MODE_NONE;
      window_parity     <= 1'b0;
      led_reg           <= 1'b0;
    end else if (update) begin
      quiet_windows     <= quiet_windows_next;
      sustained_windows <= sustained_windows_next;
      pulsed_windows    <= pulsed_windows_next;
      mode_reg          <= mode_reg_next;
      window_parity     <= window_parity_next;
      led_reg           <= led_reg_next;
    end
  end

  // The result is the state left by the latest window.
  assign led_on     = led_reg;
  assign alarm_mode = mode_reg;

endmodule

// ===== rtl/brownout_alarm_monitor.sv =====
// ----------------------------------------------------------------------------
// Brown-out alarm monitor
// Tracks sustained and pulsed brown-out windows and drives the alarm mode
// and warning LED, one result per sampling window.
// Path from input request to result: input register, then classification and
// state update into the result register. Throughput: one window per cycle
// while out_ready is high; the ready path follows out_ready.
// Reset: synchronous; counters, mode and LED clear, thresholds load defaults.
// ----------------------------------------------------------------------------
module brownout_alarm_monitor
  import bam_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  // Window input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COUNT_WIDTH-1:0] low_time_count,
  input  logic [COUNT_WIDTH-1:0] falling_edges,
  // Result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   led_on,
  output logic [1:0]             alarm_mode,
  // Configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [COUNT_WIDTH-1:0] cfg_data
);

  logic [COUNT_WIDTH-1:0] long_low_threshold;
  logic [COUNT_WIDTH-1:0] short_low_min;
  logic [COUNT_WIDTH-1:0] short_low_max;

  logic                   win_valid;
  logic [COUNT_WIDTH-1:0] win_low_time;
  logic [COUNT_WIDTH-1:0] win_edges;
  logic                   res_free;
  logic                   win_move;
  window_class_t          win_class;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_low_threshold <= COUNT_WIDTH'(LONG_LOW_RESET);
      short_low_min      <= COUNT_WIDTH'(SHORT_MIN_RESET);
      short_low_max      <= COUNT_WIDTH'(SHORT_MAX_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LONG_LOW_THRESHOLD: long_low_threshold <= cfg_data;
        REG_SHORT_LOW_MIN:      short_low_min      <= cfg_data;
        REG_SHORT_LOW_MAX:      short_low_max      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline handshake: a window moves on when the result register is free.
  assign res_free = !out_valid || out_ready;
  assign win_move = win_valid && res_free;
  assign in_ready = !win_valid || res_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (in_ready) begin
      win_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      win_low_time <= low_time_count;
      win_edges    <= falling_edges;
    end
  end

  // Result valid tracks the result register held in the tracker.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= win_valid;
    end
  end

  bam_classify #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_classify (
    .low_time           (win_low_time),
    .edges              (win_edges),
    .long_low_threshold (long_low_threshold),
    .short_low_min      (short_low_min),
    .short_low_max      (short_low_max),
    .win_class          (win_class)
  );

  bam_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .update     (win_move),
    .win_class  (win_class),
    .led_on     (led_on),
    .alarm_mode (alarm_mode)
  );

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Brown-out alarm monitor testbench
// Feeds sampling windows through the request channel, first from a short
// directed table and then as random runs of sustained, pulsed, quiet and
// fully random windows under several threshold settings. Each result is checked
// against a typed table row or an in-bench tracker of the alarm mode and LED,
// with random idling on both the request and result sides.
// ----------------------------------------------------------------------------
module tb_top;
  import bam_pkg::*;

  localparam int CW = 24;
  localparam int LATENCY = 2;
  localparam int RANDOM_WINDOWS = 400;
  localparam int NUM_PHASES = 7;
  localparam int DIRECTED_ROWS = 26;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  // The index port has room for one register that does not exist.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CW-1:0] low;
    logic [CW-1:0] edges;
    logic          typed;
    logic          led;
    logic [1:0]    mode;
  } window_row_t;

  typedef struct packed {
    logic       led;
    logic [1:0] mode;
  } alarm_result_t;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  logic [CW-1:0] low_time_count;
  logic [CW-1:0] falling_edges;
  logic          out_valid;
  logic          out_ready;
  logic          led_on;
  logic [1:0]    alarm_mode;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [1:0]    cfg_index;
  logic [CW-1:0] cfg_data;

  // Tracker copy of the thresholds and alarm state.
  logic [CW-1:0] thr_long;
  logic [CW-1:0] thr_min;
  logic [CW-1:0] thr_max;
  logic [5:0]    quiet_run;
  logic [3:0]    sust_run;
  logic [3:0]    puls_run;
  logic [1:0]    mode_q;
  logic          parity_q;
  logic          led_q;

  alarm_result_t expected_alarms[$];

  int  mismatches = 0;
  int  n_windows = 0;
  int  n_results = 0;
  int  n_reg_writes = 0;
  int  n_sustained_seen = 0;
  int  n_pulsed_seen = 0;
  int  n_phase_windows;
  bit  steady = 0;
  int  stall_left = 0;

  // Directed windows under the reset thresholds (4000000 / 80000 / 400000).
  window_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{24'd0,       24'd0,       1'b1, 1'b0, MODE_NONE},  // quiet, fresh from reset
    '{24'd4000000, 24'd1,       1'b1, 1'b0, MODE_NONE},  // at threshold, still quiet
    '{24'd4000001, 24'd0,       1'b1, 1'b0, MODE_NONE},  // first sustained window
    '{CNT_MAX,     CNT_MAX,     1'b1, 1'b0, MODE_NONE},  // field extremes
    '{24'd5000000, 24'd7,       1'b0, 1'b0, MODE_NONE},
    '{CNT_MAX,     24'd0,       1'b0, 1'b0, MODE_NONE},  // fourth in a row sets mode
    '{24'd0,       24'd0,       1'b0, 1'b0, MODE_NONE},
    '{24'd80001,   24'd2,       1'b0, 1'b0, MODE_NONE},  // pulsed, lower edge of range
    '{24'd399999,  CNT_MAX,     1'b0, 1'b0, MODE_NONE},  // pulsed, upper edge of range
    '{24'd80000,   24'd2,       1'b0, 1'b0, MODE_NONE},  // on the minimum: quiet
    '{24'd400000,  24'd2,       1'b0, 1'b0, MODE_NONE},  // on the maximum: quiet
    '{24'd200000,  24'd1,       1'b0, 1'b0, MODE_NONE},  // single edge: quiet
    '{24'd200000,  24'd3,       1'b0, 1'b0, MODE_NONE},
    '{24'd250000,  24'd2,       1'b0, 1'b0, MODE_NONE},  // fourth pulsed sets mode 2
    '{24'd0,       24'd0,       1'b0, 1'b0, MODE_NONE},  // mode 2 blinks every other
    '{24'd79999,   24'd5,       1'b0, 1'b0, MODE_NONE},
    '{24'd0,       24'd0,       1'b0, 1'b0, MODE_NONE},
    '{24'd400001,  24'd9,       1'b0, 1'b0, MODE_NONE},
    '{24'd0,       CNT_MAX,     1'b0, 1'b0, MODE_NONE},
    '{24'd1,       24'd0,       1'b0, 1'b0, MODE_NONE},
    '{24'd0,       24'd0,       1'b0, 1'b0, MODE_NONE},
    '{24'd3999999, 24'd1,       1'b0, 1'b0, MODE_NONE},
    '{24'd0,       24'd0,       1'b0, 1'b0, MODE_NONE},
    '{24'd0,       24'd0,       1'b0, 1'b0, MODE_NONE},
    '{24'd0,       24'd0,       1'b0, 1'b0, MODE_NONE},  // eleventh quiet clears runs
    '{CNT_MAX,     24'd1,       1'b0, 1'b0, MODE_NONE}   // sustained run restarts at one
  };

  brownout_alarm_monitor #(
    .COUNT_WIDTH(CW)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .low_time_count(low_time_count),
    .falling_edges (falling_edges),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .led_on        (led_on),
    .alarm_mode    (alarm_mode),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("Timeout: results still outstanding = %0d", expected_alarms.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("ERROR at %0t: %s", $time, what);
    end
  endtask

  // Mostly short gaps, sometimes none, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Updates the tracked alarm state with one window and returns the new outputs.
  task automatic track_alarm(input logic [CW-1:0] lt, input logic [CW-1:0] fe,
                             output alarm_result_t res);
    parity_q = ~parity_q;
    if (lt > thr_long) begin
      quiet_run = '0;
      if (sust_run < RUN_MAX) sust_run = sust_run + 4'd1;
      if (sust_run > RUN_TO_SET) mode_q = MODE_SUSTAINED;
    end else if (lt > thr_min && fe > 1 && lt < thr_max) begin
      quiet_run = '0;
      if (puls_run < RUN_MAX) puls_run = puls_run + 4'd1;
      if (puls_run > RUN_TO_SET) mode_q = MODE_PULSED;
    end else begin
      quiet_run = quiet_run + 6'd1;
      if (quiet_run > QUIET_TO_CLEAR_RUNS) begin
        sust_run = '0;
        puls_run = '0;
      end
      if (quiet_run > QUIET_TO_CLEAR_MODE) begin
        quiet_run = '0;
        mode_q = MODE_NONE;
      end
    end
    // Sustained blinks every window, pulsed on every even window.
    if (mode_q == MODE_SUSTAINED) begin
      led_q = ~led_q;
    end else if (mode_q == MODE_PULSED) begin
      if (!parity_q) led_q = ~led_q;
    end else begin
      led_q = 1'b0;
    end
    res.led = led_q;
    res.mode = mode_q;
  endtask

  // Presents one window, waits for its acceptance, then idles for a random gap, which may be none.
  task automatic send_window(input logic [CW-1:0] lt, input logic [CW-1:0] fe,
                             input logic typed, input alarm_result_t typed_res);
    alarm_result_t res;
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    low_time_count <= lt;
    falling_edges <= fe;
    do @(posedge clk); while (!in_ready);
    track_alarm(lt, fe, res);
    expected_alarms.push_back(typed ? typed_res : res);
    n_windows++;
    n_phase_windows++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Waits until every outstanding result has come back and the block is idle.
  task automatic drain();
    if (in_valid) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    while (expected_alarms.size() != 0) @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);
  endtask

  // Writes the three thresholds and a stray index, which must change nothing.
  task automatic set_thresholds(input logic [CW-1:0] t_long, input logic [CW-1:0] t_min,
                                input logic [CW-1:0] t_max);
    logic [1:0]    idx [4];
    logic [CW-1:0] val [4];
    idx = '{REG_LONG_LOW_THRESHOLD, REG_SHORT_LOW_MIN, REG_UNUSED, REG_SHORT_LOW_MAX};
    val = '{t_long, t_min, CW'($urandom), t_max};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_LONG_LOW_THRESHOLD: thr_long = val[i];
        REG_SHORT_LOW_MIN:      thr_min = val[i];
        REG_SHORT_LOW_MAX:      thr_max = val[i];
        default: ;
      endcase
      n_reg_writes++;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Window generators aimed at the current thresholds; fall back to noise.
  function automatic logic [CW-1:0] sustained_low();
    if (thr_long == CNT_MAX) return CW'($urandom);
    return CW'($urandom_range(32'(CNT_MAX), 32'(thr_long) + 1));
  endfunction

  function automatic logic [CW-1:0] pulsed_low();
    if (32'(thr_max) <= 32'(thr_min) + 1) return CW'($urandom);
    return CW'($urandom_range(32'(thr_max) - 1, 32'(thr_min) + 1));
  endfunction

  function automatic logic [CW-1:0] busy_edges();
    if ($urandom_range(3, 0) == 0) return CW'($urandom);
    return CW'($urandom_range(40, 2));
  endfunction

  // One run of a single window kind, with random content.
  task automatic random_run();
    int kind;
    int len;
    logic [CW-1:0] lt;
    logic [CW-1:0] fe;
    kind = $urandom_range(99, 0);
    steady = ($urandom_range(4, 0) == 0);
    if (kind < 80 && kind >= 55 && $urandom_range(9, 0) == 0) begin
      len = $urandom_range(60, 45);
    end else if (kind < 55) begin
      len = $urandom_range(18, 1);
    end else if (kind < 80) begin
      len = $urandom_range(12, 1);
    end else begin
      len = $urandom_range(4, 1);
    end
    for (int i = 0; i < len; i++) begin
      if (kind < 30) begin
        lt = sustained_low();
        fe = CW'($urandom);
      end else if (kind < 55) begin
        lt = pulsed_low();
        fe = busy_edges();
      end else if (kind < 80) begin
        // Quiet: either at most one edge, or low time at or below the minimum.
        if ($urandom_range(1, 0) == 1 && thr_min <= thr_long) begin
          lt = CW'($urandom_range(32'(thr_min), 0));
          fe = CW'($urandom);
        end else begin
          lt = CW'($urandom_range(32'(thr_long), 0));
          fe = CW'($urandom_range(1, 0));
        end
      end else begin
        lt = CW'($urandom);
        fe = CW'($urandom);
      end
      send_window(lt, fe, 1'b0, '0);
    end
    steady = 0;
  endtask

  // Result side: random stalls, none during steady stretches.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady) begin
        out_ready <= 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    alarm_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_alarms.size() == 0) begin
        report_mismatch($sformatf("unexpected result led=%0b mode=%0d", led_on, alarm_mode));
      end else begin
        want = expected_alarms.pop_front();
        n_results++;
        if (led_on !== want.led) begin
          report_mismatch($sformatf("result %0d led_on got %b want %b",
                                    n_results, led_on, want.led));
        end
        if (alarm_mode !== want.mode) begin
          report_mismatch($sformatf("result %0d alarm_mode got %0d want %0d",
                                    n_results, alarm_mode, want.mode));
        end
        if (want.mode == MODE_SUSTAINED) n_sustained_seen++;
        if (want.mode == MODE_PULSED) n_pulsed_seen++;
      end
    end
  end

  // Main sequence.
  initial begin
    logic [CW-1:0] t_min;
    alarm_result_t typed_res;
    rst = 1'b1;
    in_valid = 1'b0;
    low_time_count = '0;
    falling_edges = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_LONG_LOW_THRESHOLD;
    cfg_data = '0;

    thr_long = LONG_LOW_RESET[CW-1:0];
    thr_min = SHORT_MIN_RESET[CW-1:0];
    thr_max = SHORT_MAX_RESET[CW-1:0];
    quiet_run = '0;
    sust_run = '0;
    puls_run = '0;
    mode_q = MODE_NONE;
    parity_q = 1'b0;
    led_q = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table under the reset thresholds.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      typed_res.led = directed_rows[i].led;
      typed_res.mode = directed_rows[i].mode;
      send_window(directed_rows[i].low, directed_rows[i].edges,
                  directed_rows[i].typed, typed_res);
    end

    // Random runs, one threshold setting per phase.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0: ;  // keep the reset thresholds
        1: set_thresholds('0, '0, '0);
        2: set_thresholds(CNT_MAX, CNT_MAX, CNT_MAX);
        3: begin
          // Inverted pulsed range: nothing can be pulsed.
          t_min = CW'($urandom_range(1 << 20, 2));
          set_thresholds(CW'($urandom_range(1 << 22, 0)), t_min,
                         CW'($urandom_range(32'(t_min), 0)));
        end
        6: begin
          // Long threshold below the pulsed range.
          t_min = CW'($urandom_range(1 << 20, 1000));
          set_thresholds(CW'($urandom_range(32'(t_min), 0)), t_min,
                         CW'(32'(t_min) + $urandom_range(1 << 20, 2)));
        end
        default: begin
          t_min = CW'($urandom_range(1 << 20, 0));
          set_thresholds(CW'(32'(t_min) + $urandom_range(1 << 22, 1 << 20)), t_min,
                         CW'(32'(t_min) + $urandom_range(1 << 20, 2)));
        end
      endcase
      n_phase_windows = 0;
      while (n_phase_windows < RANDOM_WINDOWS / NUM_PHASES) random_run();
    end

    drain();
    $display("Checked %0d results from %0d windows across %0d threshold settings",
             n_results, n_windows, NUM_PHASES);
    $display("Register writes: %0d; results in sustained alarm: %0d, in pulsed alarm: %0d",
             n_reg_writes, n_sustained_seen, n_pulsed_seen);
    if (expected_alarms.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_alarms.size()));
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
